[rtl/core/sorted_key_extents_lookup_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the sorted key extents lookup
// Shared wrappers that give every concurrent check the same clocking and
// reset handling.
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_EXTENTS_LOOKUP_ASSERT_SVH
`define SORTED_KEY_EXTENTS_LOOKUP_ASSERT_SVH

// General form: explicit clock and active-low reset.
`define SKEL_ASSERT_AT(lbl, ck, rst_n, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) prop) \
	else $error(msg);

// Short form for modules that use the block's own clock and reset names.
`define SKEL_ASSERT(lbl, prop, msg) \
	`SKEL_ASSERT_AT(lbl, clk, arst_n, prop, msg)

`endif

[rtl/core/skel_pkg.sv]
// ----------------------------------------------------------------------------
// Sorted key extents lookup package
// Field widths, status and mode codes, register indexes, storage types and
// helper functions shared by the lookup and its checker.
// ----------------------------------------------------------------------------
package skel_pkg;

	// Default sizing of the stores.
	localparam int unsigned MAX_ENTRIES_DEF = 256;
	localparam int unsigned ROWS_DEF        = 4096;
	localparam int unsigned TABLES_DEF      = 2;

	// Fixed field widths.
	localparam int unsigned MODE_W    = 2;
	localparam int unsigned SLOT_W    = 12;
	localparam int unsigned KEY_W     = 16;
	localparam int unsigned FRAMES_W  = 16;
	localparam int unsigned BASE_W    = 12;
	localparam int unsigned WORD_W    = 32;
	localparam int unsigned STATUS_W  = 3;
	localparam int unsigned CNT_W     = 9;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DAT_W = 9;

	// Signed search bounds span -1 up to the largest count.
	localparam int unsigned SRCH_W   = CNT_W + 1;
	// Row base plus a clamped frame never exceeds this width.
	localparam int unsigned ROWSUM_W = FRAMES_W + 1;

	// Item modes.
	localparam logic [MODE_W-1:0] MODE_LOAD_ENTRY = 2'd0;
	localparam logic [MODE_W-1:0] MODE_LOAD_ROW   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_QUERY      = 2'd2;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
	localparam logic [STATUS_W-1:0] ST_KEY      = 3'd1;
	localparam logic [STATUS_W-1:0] ST_READY    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_MISSING  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NOFRAMES = 3'd4;
	localparam logic [STATUS_W-1:0] ST_NAN      = 3'd5;
	localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd6;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_TABLES_READY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES_T0   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES_T1   = 2'd2;

	// One directory entry.
	typedef struct packed {
		logic [BASE_W-1:0]   row_base;
		logic [FRAMES_W-1:0] frames;
		logic [KEY_W-1:0]    key;
	} dir_entry_t;

	// One extents row of four float words.
	typedef struct packed {
		logic [WORD_W-1:0] w3;
		logic [WORD_W-1:0] w2;
		logic [WORD_W-1:0] w1;
		logic [WORD_W-1:0] w0;
	} ext_row_t;

	// A float32 pattern is a NaN when the exponent is all ones and the
	// mantissa is nonzero; infinities pass.
	function automatic logic word_is_nan(input logic [WORD_W-1:0] w);
		return (w[30:23] == 8'hFF) && (w[22:0] != 23'd0);
	endfunction

endpackage

[rtl/core/sorted_key_extents_lookup.sv]
// ----------------------------------------------------------------------------
// Sorted key extents lookup
// Per-table sorted directory with binary search, frame clamp and extents
// row fetch, plus load paths for directory entries and rows.
// ----------------------------------------------------------------------------
// Load items and queries rejected up front return their result in the cycle
// after acceptance. Each probe of a searching query goes through the single
// registered read port of the directory memory and then the one key
// comparator; a search makes up to ceil(log2(N + 1)) probes for N entries,
// followed by a frame clamp step, a row read and a result step. The block
// takes one request at a time and holds stall high until the result has
// moved into the output register. Both stores power up undefined and need
// no clearing pass; entries and rows must be loaded before they are read,
// and directory keys must be loaded in ascending order.
module sorted_key_extents_lookup #(
	parameter int unsigned MAX_ENTRIES = skel_pkg::MAX_ENTRIES_DEF,
	parameter int unsigned ROWS        = skel_pkg::ROWS_DEF,
	parameter int unsigned TABLES      = skel_pkg::TABLES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Configuration write channel.
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [skel_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [skel_pkg::CFG_DAT_W-1:0] cfg_data,
	// Input request channel.
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [skel_pkg::MODE_W-1:0]    mode,
	input  logic                           table_select,
	input  logic [skel_pkg::SLOT_W-1:0]    slot,
	input  logic [skel_pkg::KEY_W-1:0]     entry_key,
	input  logic [skel_pkg::FRAMES_W-1:0]  entry_frames,
	input  logic [skel_pkg::BASE_W-1:0]    entry_row_base,
	input  logic [skel_pkg::WORD_W-1:0]    row_word0,
	input  logic [skel_pkg::WORD_W-1:0]    row_word1,
	input  logic [skel_pkg::WORD_W-1:0]    row_word2,
	input  logic [skel_pkg::WORD_W-1:0]    row_word3,
	input  logic [31:0]                    query_key,
	input  logic signed [31:0]             query_frame,
	// Result channel.
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [skel_pkg::STATUS_W-1:0]  status,
	output logic [skel_pkg::WORD_W-1:0]    min_x_bits,
	output logic [skel_pkg::WORD_W-1:0]    max_x_bits,
	output logic [skel_pkg::WORD_W-1:0]    min_y_bits,
	output logic [skel_pkg::WORD_W-1:0]    max_y_bits
);

	import skel_pkg::*;

	// Derived sizes.
	localparam int unsigned EIW       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int unsigned RIW       = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int unsigned TW        = (TABLES > 1) ? $clog2(TABLES) : 1;
	localparam int unsigned DIR_DEPTH = TABLES * (2 ** EIW);
	localparam int unsigned EXT_DEPTH = TABLES * (2 ** RIW);
	localparam int unsigned DIR_AW    = (DIR_DEPTH > 1) ? $clog2(DIR_DEPTH) : 1;
	localparam int unsigned EXT_AW    = (EXT_DEPTH > 1) ? $clog2(EXT_DEPTH) : 1;

	// Sequencer states.
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_PROBE = 3'd1;
	localparam logic [2:0] S_CMP   = 3'd2;
	localparam logic [2:0] S_FRAME = 3'd3;
	localparam logic [2:0] S_ROW   = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	logic [2:0]                state_q, state_d;
	logic                      out_valid_q;
	logic                      tables_ready_q;
	logic [CNT_W-1:0]          cnt0_q, cnt1_q;

	logic [TW-1:0]             tsel_q;
	logic [KEY_W-1:0]          key_q;
	logic signed [31:0]        frame_q;
	logic signed [SRCH_W-1:0]  lo_q, hi_q, mid_q;
	logic [STATUS_W-1:0]       res_status_q;

	logic [STATUS_W-1:0]       status_q;
	ext_row_t                  data_q;

	dir_entry_t                dir_mem [DIR_DEPTH];
	ext_row_t                  ext_mem [EXT_DEPTH];
	dir_entry_t                dir_rd_q;
	ext_row_t                  ext_rd_q;

	logic                      in_acc, out_free, tbl_ok, key_bad, ready_ok;
	logic [TW-1:0]             tsel_in;
	logic [CNT_W-1:0]          cnt_sel, cnt_eff;
	logic signed [SRCH_W-1:0]  diff, mid;
	logic                      dir_we, ext_we, dir_re, ext_re;
	logic [DIR_AW-1:0]         dir_waddr, dir_raddr;
	logic [EXT_AW-1:0]         ext_waddr, ext_raddr;
	logic                      frame_big;
	logic [FRAMES_W-1:0]       f_clamp;
	logic [ROWSUM_W-1:0]       row_sum;
	logic                      row_ok, row_nan;
	logic                      out_load, search_init, res_set, lo_step, hi_step;
	logic [STATUS_W-1:0]       out_status_d, res_status_d;
	ext_row_t                  out_data_d;

	// Handshakes.
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE) || !out_free;
	assign in_acc    = in_valid && !in_stall;

	// Request decode and up-front query checks.
	assign tsel_in  = TW'(table_select);
	assign tbl_ok   = 32'(table_select) < TABLES;
	assign key_bad  = query_key[31:KEY_W] != '0;
	assign cnt_sel  = table_select ? cnt1_q : cnt0_q;
	assign cnt_eff  = (32'(cnt_sel) > MAX_ENTRIES) ? CNT_W'(MAX_ENTRIES) : cnt_sel;
	assign ready_ok = tables_ready_q && tbl_ok && (cnt_eff != '0);

	// Store writes for load requests.
	assign dir_we    = in_acc && (mode == MODE_LOAD_ENTRY) && tbl_ok
			&& (32'(slot) < MAX_ENTRIES);
	assign ext_we    = in_acc && (mode == MODE_LOAD_ROW) && tbl_ok && (32'(slot) < ROWS);
	assign dir_waddr = DIR_AW'({tsel_in, EIW'(slot)});
	assign ext_waddr = EXT_AW'({tsel_in, RIW'(slot)});

	// Probe midpoint; the sequencer only uses it while lo <= hi.
	assign diff      = hi_q - lo_q;
	assign mid       = lo_q + (diff >>> 1);
	assign dir_raddr = DIR_AW'({tsel_q, EIW'($unsigned(mid))});

	// Frame clamp and row address from the matched entry.
	assign frame_big = (frame_q[30:FRAMES_W] != '0) || (frame_q[FRAMES_W-1:0] >= dir_rd_q.frames);
	assign f_clamp   = frame_q[31] ? '0 :
			(frame_big ? (dir_rd_q.frames - 1'b1) : frame_q[FRAMES_W-1:0]);
	assign row_sum   = ROWSUM_W'(dir_rd_q.row_base) + ROWSUM_W'(f_clamp);
	assign row_ok    = 32'(row_sum) < ROWS;
	assign ext_raddr = EXT_AW'({tsel_q, RIW'(row_sum)});

	// NaN screen over the fetched row.
	assign row_nan = word_is_nan(ext_rd_q.w0) || word_is_nan(ext_rd_q.w1)
			|| word_is_nan(ext_rd_q.w2) || word_is_nan(ext_rd_q.w3);

	// Sequencer next state and step controls.
	always_comb begin
		state_d      = state_q;
		out_load     = 1'b0;
		out_status_d = ST_OK;
		out_data_d   = '0;
		search_init  = 1'b0;
		res_set      = 1'b0;
		res_status_d = ST_OK;
		lo_step      = 1'b0;
		hi_step      = 1'b0;
		dir_re       = 1'b0;
		ext_re       = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					if (mode != MODE_QUERY) begin
						out_load = 1'b1;
					end else if (key_bad) begin
						out_load     = 1'b1;
						out_status_d = ST_KEY;
					end else if (!ready_ok) begin
						out_load     = 1'b1;
						out_status_d = ST_READY;
					end else begin
						search_init = 1'b1;
						state_d     = S_PROBE;
					end
				end
			end
			S_PROBE: begin
				if (lo_q <= hi_q) begin
					dir_re  = 1'b1;
					state_d = S_CMP;
				end else begin
					res_set      = 1'b1;
					res_status_d = ST_MISSING;
					state_d      = S_DONE;
				end
			end
			S_CMP: begin
				if (dir_rd_q.key == key_q) begin
					state_d = S_FRAME;
				end else begin
					lo_step = dir_rd_q.key < key_q;
					hi_step = dir_rd_q.key > key_q;
					state_d = S_PROBE;
				end
			end
			S_FRAME: begin
				if (dir_rd_q.frames == '0) begin
					res_set      = 1'b1;
					res_status_d = ST_NOFRAMES;
					state_d      = S_DONE;
				end else if (!row_ok) begin
					res_set      = 1'b1;
					res_status_d = ST_RANGE;
					state_d      = S_DONE;
				end else begin
					ext_re  = 1'b1;
					state_d = S_ROW;
				end
			end
			S_ROW: begin
				res_set      = 1'b1;
				res_status_d = row_nan ? ST_NAN : ST_OK;
				state_d      = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					out_load     = 1'b1;
					out_status_d = res_status_q;
					out_data_d   = (res_status_q == ST_OK) ? ext_rd_q : '0;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control state and configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			out_valid_q    <= 1'b0;
			tables_ready_q <= 1'b0;
			cnt0_q         <= '0;
			cnt1_q         <= '0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_TABLES_READY: tables_ready_q <= cfg_data[0];
					CFG_ENTRIES_T0:   cnt0_q <= cfg_data;
					CFG_ENTRIES_T1:   cnt1_q <= cfg_data;
					default: begin
					end
				endcase
			end
		end
	end

	// Search registers and result payload.
	always_ff @(posedge clk) begin
		if (search_init) begin
			tsel_q  <= tsel_in;
			key_q   <= query_key[KEY_W-1:0];
			frame_q <= query_frame;
			lo_q    <= '0;
			hi_q    <= $signed({1'b0, cnt_eff}) - SRCH_W'(1);
		end
		if (dir_re) begin
			mid_q <= mid;
		end
		if (lo_step) begin
			lo_q <= mid_q + SRCH_W'(1);
		end
		if (hi_step) begin
			hi_q <= mid_q - SRCH_W'(1);
		end
		if (res_set) begin
			res_status_q <= res_status_d;
		end
		if (out_load) begin
			status_q <= out_status_d;
			data_q   <= out_data_d;
		end
	end

	// Directory memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (dir_we) begin
			dir_mem[dir_waddr] <= '{row_base: entry_row_base, frames: entry_frames,
				key: entry_key};
		end
		if (dir_re) begin
			dir_rd_q <= dir_mem[dir_raddr];
		end
	end

	// Extents memory: one row of four words per address.
	always_ff @(posedge clk) begin
		if (ext_we) begin
			ext_mem[ext_waddr] <= '{w3: row_word3, w2: row_word2, w1: row_word1,
				w0: row_word0};
		end
		if (ext_re) begin
			ext_rd_q <= ext_mem[ext_raddr];
		end
	end

	// Result outputs.
	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign min_x_bits = data_q.w0;
	assign max_x_bits = data_q.w1;
	assign min_y_bits = data_q.w2;
	assign max_y_bits = data_q.w3;

endmodule

[rtl/core/skel_checker.sv]
// ----------------------------------------------------------------------------
// Sorted key extents lookup port checker
// Watches the top-level ports for result ordering and payload rules and is
// bound to every instance of the lookup.
// ----------------------------------------------------------------------------
`include "sorted_key_extents_lookup_assert.svh"

module skel_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_stall,
	input logic [skel_pkg::MODE_W-1:0]    mode,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic [skel_pkg::STATUS_W-1:0]  status,
	input logic [skel_pkg::WORD_W-1:0]    min_x_bits,
	input logic [skel_pkg::WORD_W-1:0]    max_x_bits,
	input logic [skel_pkg::WORD_W-1:0]    min_y_bits,
	input logic [skel_pkg::WORD_W-1:0]    max_y_bits
);

	import skel_pkg::*;

	// A stalled result stays offered.
	`SKEL_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "result dropped while stalled")

	// A stalled result keeps its payload.
	`SKEL_ASSERT(a_out_stable, out_valid && out_stall |=> $stable(status) && $stable(min_x_bits) && $stable(max_x_bits) && $stable(min_y_bits) && $stable(max_y_bits), "result changed while stalled")

	// Every non-query request answers OK in the very next cycle.
	`SKEL_ASSERT(a_load_result, in_valid && !in_stall && (mode != MODE_QUERY) |=> out_valid && (status == ST_OK) && (min_x_bits == '0) && (max_y_bits == '0), "load request result missing")

	// Any failure status carries zero data.
	`SKEL_ASSERT(a_fail_zero, out_valid && (status != ST_OK) |-> (min_x_bits == '0) && (max_x_bits == '0) && (min_y_bits == '0) && (max_y_bits == '0), "failure result with nonzero data")

endmodule

bind sorted_key_extents_lookup skel_checker u_skel_checker (.*);
